[sv/psd_pkg.sv]
package psd_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int DIST_WIDTH  = 26;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int WORD_WIDTH  = 64;
    localparam int HALF_WIDTH  = WORD_WIDTH / 2;
    localparam int WIDE_WIDTH  = 2 * WORD_WIDTH;

    typedef struct packed {
        logic                          op;
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic signed [COORD_WIDTH-1:0] query_x;
        logic signed [COORD_WIDTH-1:0] query_y;
    } psd_in_t;

    typedef struct packed {
        logic [DIST_WIDTH-1:0] distance;
        logic                  used_endpoint;
        logic                  degenerate;
    } psd_out_t;

    // One lane of the bit-by-bit root search: largest root with root*root*den <= num.
    typedef struct packed {
        logic [WIDE_WIDTH-1:0] num;
        logic [WORD_WIDTH-1:0] den;
        logic [WIDE_WIDTH-1:0] acc_sq;   // root*root*den
        logic [WIDE_WIDTH-1:0] acc_lin;  // root*den
        logic [DIST_WIDTH-1:0] root;
    } root_lane_t;

    typedef struct packed {
        logic perp;
        logic used;
        logic degen;
    } psd_flags_t;

    typedef struct packed {
        logic [WIDE_WIDTH-1:0] num_a;
        logic [WORD_WIDTH-1:0] den_a;
        logic [WORD_WIDTH-1:0] num_b;
        psd_flags_t            flags;
    } psd_front_t;

endpackage

[sv/psd_front.sv]
module psd_front
    import psd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  psd_in_t    in_item,
    output logic       out_valid,
    output psd_front_t out_front
);

    // Stage 1: coordinate differences.
    logic                         s1_valid_reg;
    logic signed [DIFF_WIDTH-1:0] dxa_reg, dya_reg, dxb_reg, dyb_reg, dxc_reg, dyc_reg;

    // Stage 2: products.
    logic                         s2_valid_reg;
    logic signed [PROD_WIDTH-1:0] aa_x_reg, aa_y_reg, ab_x_reg, ab_y_reg;
    logic signed [PROD_WIDTH-1:0] cr_p_reg, cr_n_reg;
    logic signed [PROD_WIDTH-1:0] bb_x_reg, bb_y_reg, cc_x_reg, cc_y_reg;

    // The mode bit rides with the differences; it is only needed at stage 3.
    logic op1_reg, op2_reg;

    // Stage 3: sums taken modulo the word width.
    logic                  s3_valid_reg;
    logic [WORD_WIDTH-1:0] crm_reg, b3_reg, s1_3_reg, s2_3_reg;
    psd_flags_t            f3_reg;
    logic [WORD_WIDTH-1:0] b_next, t_next, cr_next, crm_next, s1_next, s2_next;
    psd_flags_t            f3_next;

    // Stage 4: partial products of the squared cross product.
    logic                  s4_valid_reg;
    logic [WORD_WIDTH-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [WORD_WIDTH-1:0] b4_reg, s1_4_reg, s2_4_reg;
    psd_flags_t            f4_reg;

    // Stage 5: numerator and denominator selection.
    logic                  s5_valid_reg;
    psd_front_t            s5_reg;
    psd_front_t            s5_next;
    logic [WIDE_WIDTH-1:0] cr_sq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxa_reg <= DIFF_WIDTH'(in_item.end_x) - DIFF_WIDTH'(in_item.start_x);
            dya_reg <= DIFF_WIDTH'(in_item.end_y) - DIFF_WIDTH'(in_item.start_y);
            dxb_reg <= DIFF_WIDTH'(in_item.query_x) - DIFF_WIDTH'(in_item.start_x);
            dyb_reg <= DIFF_WIDTH'(in_item.query_y) - DIFF_WIDTH'(in_item.start_y);
            dxc_reg <= DIFF_WIDTH'(in_item.query_x) - DIFF_WIDTH'(in_item.end_x);
            dyc_reg <= DIFF_WIDTH'(in_item.query_y) - DIFF_WIDTH'(in_item.end_y);
            op1_reg <= in_item.op;

            aa_x_reg <= PROD_WIDTH'(dxa_reg) * PROD_WIDTH'(dxa_reg);
            aa_y_reg <= PROD_WIDTH'(dya_reg) * PROD_WIDTH'(dya_reg);
            ab_x_reg <= PROD_WIDTH'(dxa_reg) * PROD_WIDTH'(dxb_reg);
            ab_y_reg <= PROD_WIDTH'(dya_reg) * PROD_WIDTH'(dyb_reg);
            cr_p_reg <= PROD_WIDTH'(dxa_reg) * PROD_WIDTH'(dyb_reg);
            cr_n_reg <= PROD_WIDTH'(dya_reg) * PROD_WIDTH'(dxb_reg);
            bb_x_reg <= PROD_WIDTH'(dxb_reg) * PROD_WIDTH'(dxb_reg);
            bb_y_reg <= PROD_WIDTH'(dyb_reg) * PROD_WIDTH'(dyb_reg);
            cc_x_reg <= PROD_WIDTH'(dxc_reg) * PROD_WIDTH'(dxc_reg);
            cc_y_reg <= PROD_WIDTH'(dyc_reg) * PROD_WIDTH'(dyc_reg);
            op2_reg  <= op1_reg;

            crm_reg  <= crm_next;
            b3_reg   <= b_next;
            s1_3_reg <= s1_next;
            s2_3_reg <= s2_next;
            f3_reg   <= f3_next;

            p00_reg  <= WORD_WIDTH'(crm_reg[HALF_WIDTH-1:0])
                        * WORD_WIDTH'(crm_reg[HALF_WIDTH-1:0]);
            p01_reg  <= WORD_WIDTH'(crm_reg[HALF_WIDTH-1:0])
                        * WORD_WIDTH'(crm_reg[WORD_WIDTH-1:HALF_WIDTH]);
            p10_reg  <= WORD_WIDTH'(crm_reg[WORD_WIDTH-1:HALF_WIDTH])
                        * WORD_WIDTH'(crm_reg[HALF_WIDTH-1:0]);
            p11_reg  <= WORD_WIDTH'(crm_reg[WORD_WIDTH-1:HALF_WIDTH])
                        * WORD_WIDTH'(crm_reg[WORD_WIDTH-1:HALF_WIDTH]);
            b4_reg   <= b3_reg;
            s1_4_reg <= s1_3_reg;
            s2_4_reg <= s2_3_reg;
            f4_reg   <= f3_reg;

            s5_reg   <= s5_next;
        end
    end

    always_comb
    begin
        b_next   = WORD_WIDTH'(aa_x_reg) + WORD_WIDTH'(aa_y_reg);
        t_next   = WORD_WIDTH'(ab_x_reg) + WORD_WIDTH'(ab_y_reg);
        cr_next  = WORD_WIDTH'(cr_p_reg) - WORD_WIDTH'(cr_n_reg);
        crm_next = cr_next[WORD_WIDTH-1] ? (~cr_next + 1'b1) : cr_next;
        s1_next  = WORD_WIDTH'(bb_x_reg) + WORD_WIDTH'(bb_y_reg);
        s2_next  = WORD_WIDTH'(cc_x_reg) + WORD_WIDTH'(cc_y_reg);

        f3_next.degen = (b_next == '0);
        // A projection parameter of exactly 0 or 1 still counts as inside.
        f3_next.perp  = !f3_next.degen
                        && (op2_reg || (!t_next[WORD_WIDTH-1] && t_next <= b_next));
        f3_next.used  = !f3_next.perp;
    end

    always_comb
    begin
        cr_sq = WIDE_WIDTH'(p00_reg)
              + (WIDE_WIDTH'(p01_reg) << HALF_WIDTH)
              + (WIDE_WIDTH'(p10_reg) << HALF_WIDTH)
              + (WIDE_WIDTH'(p11_reg) << WORD_WIDTH);

        s5_next.flags = f4_reg;
        s5_next.num_b = s2_4_reg;
        if (f4_reg.perp)
        begin
            s5_next.num_a = cr_sq;
            s5_next.den_a = b4_reg;
        end
        else
        begin
            s5_next.num_a = WIDE_WIDTH'(s1_4_reg);
            s5_next.den_a = WORD_WIDTH'(1);
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_front = s5_reg;

endmodule

[sv/psd_root_cell.sv]
module psd_root_cell
    import psd_pkg::*;
#(
    parameter int BIT = DIST_WIDTH - 1
)
(
    input  logic       clk,
    input  logic       en,
    input  root_lane_t lane_in,
    output root_lane_t lane_out
);

    root_lane_t            lane_reg, lane_next;
    logic [WIDE_WIDTH-1:0] den_wide, cand;
    logic                  take;

    // (root + 2^BIT)^2 * den = acc_sq + acc_lin * 2^(BIT+1) + den * 2^(2*BIT)
    always_comb
    begin
        den_wide  = WIDE_WIDTH'(lane_in.den);
        cand      = lane_in.acc_sq + (lane_in.acc_lin << (BIT + 1)) + (den_wide << (2 * BIT));
        take      = (cand <= lane_in.num);
        lane_next = lane_in;
        if (take)
        begin
            lane_next.acc_sq  = cand;
            lane_next.acc_lin = lane_in.acc_lin + (den_wide << BIT);
            lane_next.root    = lane_in.root | (DIST_WIDTH'(1) << BIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

[sv/point_segment_distance.sv]
// Distance from a query point to a segment (op = 0) or to the infinite line through it
// (op = 1), on signed fixed-point coordinates with 8 fraction bits. The result is the
// exact distance rounded down, with 8 fraction bits. When the nearest point is an endpoint,
// used_endpoint is set; when start and end coincide the distance is to the start point and
// both used_endpoint and degenerate are set. The block is fully pipelined: it takes one
// transfer per cycle while the output side keeps up, and each item passes through five
// arithmetic stages, one cell per result bit in the root search, and the output register.
// The root search is a row of 26 identical cells, each deciding one bit of the result
// with a shift-add and compare; two rows run side by side so that both endpoint distances
// are ready together. A stall on the output holds the whole pipeline.
module point_segment_distance
    import psd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  psd_in_t  in_item,
    output logic     out_valid,
    input  logic     out_ready,
    output psd_out_t out_item
);

    logic       adv;
    logic       front_valid;
    psd_front_t front;

    root_lane_t lane_a_head, lane_b_head;
    root_lane_t lane_a [DIST_WIDTH+1];
    root_lane_t lane_b [DIST_WIDTH+1];

    logic       side_valid_reg [DIST_WIDTH];
    psd_flags_t side_flags_reg [DIST_WIDTH];

    logic                  out_valid_reg;
    psd_out_t              out_item_reg, out_item_next;
    logic [DIST_WIDTH-1:0] root_a, root_b;
    psd_flags_t            last_flags;

    // The whole pipeline moves whenever the output register is empty or being emptied.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    psd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .out_valid (front_valid),
        .out_front (front)
    );

    // Lane A carries either the perpendicular ratio or the start-point distance;
    // lane B always carries the end-point distance.
    always_comb
    begin
        lane_a_head.num     = front.num_a;
        lane_a_head.den     = front.den_a;
        lane_a_head.acc_sq  = '0;
        lane_a_head.acc_lin = '0;
        lane_a_head.root    = '0;
        lane_b_head.num     = WIDE_WIDTH'(front.num_b);
        lane_b_head.den     = WORD_WIDTH'(1);
        lane_b_head.acc_sq  = '0;
        lane_b_head.acc_lin = '0;
        lane_b_head.root    = '0;
    end

    assign lane_a[0] = lane_a_head;
    assign lane_b[0] = lane_b_head;

    for (genvar i = 0; i < DIST_WIDTH; i++)
    begin : g_cells
        psd_root_cell #(.BIT(DIST_WIDTH - 1 - i)) u_cell_a (
            .clk      (clk),
            .en       (adv),
            .lane_in  (lane_a[i]),
            .lane_out (lane_a[i+1])
        );
        psd_root_cell #(.BIT(DIST_WIDTH - 1 - i)) u_cell_b (
            .clk      (clk),
            .en       (adv),
            .lane_in  (lane_b[i]),
            .lane_out (lane_b[i+1])
        );
    end

    // Valid bits and flags travel alongside the cells.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIST_WIDTH; i++)
            begin
                side_valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            side_valid_reg[0] <= front_valid;
            for (int i = 1; i < DIST_WIDTH; i++)
            begin
                side_valid_reg[i] <= side_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_flags_reg[0] <= front.flags;
            for (int i = 1; i < DIST_WIDTH; i++)
            begin
                side_flags_reg[i] <= side_flags_reg[i-1];
            end
        end
    end

    // In the endpoint case the nearer endpoint wins; on a tie both values are equal.
    always_comb
    begin
        root_a     = lane_a[DIST_WIDTH].root;
        root_b     = lane_b[DIST_WIDTH].root;
        last_flags = side_flags_reg[DIST_WIDTH-1];
        out_item_next.used_endpoint = last_flags.used;
        out_item_next.degenerate    = last_flags.degen;
        if (last_flags.perp || last_flags.degen || root_a <= root_b)
        begin
            out_item_next.distance = root_a;
        end
        else
        begin
            out_item_next.distance = root_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= side_valid_reg[DIST_WIDTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // A degenerate segment is always measured to an endpoint.
    a_degen_used : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_item.degenerate || out_item.used_endpoint))
        else $error("degenerate result without used_endpoint");

    // A finished item in the last cell reaches the output register when the pipe moves.
    a_last_to_out : assert property (@(posedge clk) disable iff (!rst_n)
        (adv && side_valid_reg[DIST_WIDTH-1]) |=> out_valid)
        else $error("result lost between the root cells and the output register");

    // Intake only stops while a result waits to be taken.
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without an output stall");

endmodule

[verif/tb.sv]
module tb;
    import psd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The drain wait after the last result covers the pipeline depth with margin.
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic OP_SEGMENT = 1'b0;
    localparam logic OP_LINE    = 1'b1;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    psd_in_t  in_item;
    logic     out_valid;
    logic     out_ready;
    psd_out_t out_item;

    point_segment_distance uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Queries waiting to be driven, and distances waiting to come out.
    psd_in_t  query_queue[$];
    psd_out_t distance_queue[$];
    int       mismatch_count;
    int       cycle_count;
    bit       stimulus_done;
    // Set by the stimulus process to make the output side hold off for a while.
    int       hold_off_cycles;

    function automatic void add_query(psd_in_t q);
        query_queue.insert(query_queue.size(), q);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Largest d below 2^26 with d*d*den <= num, found bit by bit. The products
    // are held at 192 bits so that nothing can wrap.
    function automatic logic [25:0] floor_root_ratio(logic [127:0] num, logic [63:0] den);
        logic [25:0]  root;
        logic [25:0]  trial;
        logic [191:0] prod;
        root = '0;
        for (int b = 25; b >= 0; b--)
        begin
            trial = root | (26'd1 << b);
            prod  = {166'd0, trial} * {166'd0, trial} * {128'd0, den};
            if (prod <= {64'd0, num})
                root = trial;
        end
        return root;
    endfunction

    // Distance prediction in exact signed arithmetic; 24-bit coordinates keep
    // every intermediate well within 64 bits.
    function automatic psd_out_t predict_distance(psd_in_t q);
        psd_out_t     r;
        logic signed [63:0] sx, sy, ex, ey, qx, qy;
        logic signed [63:0] dxa, dya, dxb, dyb, len_sq, proj, cross_prod;
        logic [63:0]  d1, d2, mag_cross;
        sx = q.start_x; sy = q.start_y;
        ex = q.end_x;   ey = q.end_y;
        qx = q.query_x; qy = q.query_y;
        dxa = ex - sx; dya = ey - sy;
        dxb = qx - sx; dyb = qy - sy;
        len_sq = dxa * dxa + dya * dya;
        proj   = dxa * dxb + dya * dyb;
        r = '0;
        if (len_sq == 0)
        begin
            r.distance      = floor_root_ratio(128'(dxb * dxb + dyb * dyb), 64'd1);
            r.used_endpoint = 1'b1;
            r.degenerate    = 1'b1;
        end
        else if (q.op == OP_LINE || (proj >= 0 && proj <= len_sq))
        begin
            cross_prod = dxa * dyb - dya * dxb;
            mag_cross  = (cross_prod < 0) ? -cross_prod : cross_prod;
            r.distance = floor_root_ratio({64'd0, mag_cross} * {64'd0, mag_cross}, len_sq);
        end
        else
        begin
            d1 = floor_root_ratio(128'(dxb * dxb + dyb * dyb), 64'd1);
            d2 = floor_root_ratio(128'((qx - ex) * (qx - ex) + (qy - ey) * (qy - ey)), 64'd1);
            r.distance      = (d1 > d2) ? d2[25:0] : d1[25:0];
            r.used_endpoint = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [23:0] random_coord();
        case ($urandom_range(0, 5))
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 4095)) - 24'd2048;
            2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 23'($urandom)};
            3: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            default: return 24'($urandom_range(0, 255)) - 24'd128;
        endcase
    endfunction

    function automatic psd_in_t random_query();
        psd_in_t q;
        q.op      = 1'($urandom_range(0, 1));
        q.start_x = random_coord();
        q.start_y = random_coord();
        q.end_x   = random_coord();
        q.end_y   = random_coord();
        q.query_x = random_coord();
        q.query_y = random_coord();
        // Now and then the endpoints coincide, or the query sits on an endpoint.
        case ($urandom_range(0, 9))
            0: begin q.end_x = q.start_x; q.end_y = q.start_y; end
            1: begin q.query_x = q.end_x; q.query_y = q.end_y; end
            default: ;
        endcase
        return q;
    endfunction

    function automatic psd_in_t make_query(logic op, int sx, int sy, int ex, int ey,
                                           int qx, int qy);
        psd_in_t q;
        q.op = op;
        q.start_x = 24'(sx); q.start_y = 24'(sy);
        q.end_x   = 24'(ex); q.end_y   = 24'(ey);
        q.query_x = 24'(qx); q.query_y = 24'(qy);
        return q;
    endfunction

    // Stimulus: directed corner cases first, then random queries, with one
    // long output stall in the middle to fill the pipeline.
    initial
    begin
        hold_off_cycles = 0;
        stimulus_done   = 1'b0;
        // Projection strictly inside, exactly at the start, exactly at the end.
        add_query(make_query(OP_SEGMENT, 0, 0, 2560, 0, 1280, 768));
        add_query(make_query(OP_SEGMENT, 0, 0, 2560, 0, 0, 768));
        add_query(make_query(OP_SEGMENT, 0, 0, 2560, 0, 2560, -768));
        // Projection before the start and past the end, in both modes.
        add_query(make_query(OP_SEGMENT, 0, 0, 2560, 0, -512, 300));
        add_query(make_query(OP_SEGMENT, 0, 0, 2560, 0, 3000, -300));
        add_query(make_query(OP_LINE, 0, 0, 2560, 0, -512, 300));
        add_query(make_query(OP_LINE, 0, 0, 2560, 0, 3000, -300));
        // Coincident endpoints in both modes.
        add_query(make_query(OP_SEGMENT, 100, -50, 100, -50, 400, 350));
        add_query(make_query(OP_LINE, 100, -50, 100, -50, -400, 350));
        // Query on the segment and on an endpoint.
        add_query(make_query(OP_SEGMENT, -256, -256, 256, 256, 0, 0));
        add_query(make_query(OP_SEGMENT, -256, -256, 256, 256, 256, 256));
        // Diagonal segment with an irrational distance.
        add_query(make_query(OP_LINE, 0, 0, 333, 777, -1000, 123));
        // Coordinate extremes.
        add_query(make_query(OP_SEGMENT, -8388608, -8388608, 8388607, 8388607,
                             8388607, -8388608));
        add_query(make_query(OP_LINE, -8388608, -8388608, 8388607, 8388607,
                             -8388608, 8388607));
        add_query(make_query(OP_SEGMENT, 8388607, 8388607, 8388607, 8388607,
                             -8388608, -8388608));
        add_query(make_query(OP_SEGMENT, -8388608, 0, 8388607, 0,
                             -8388608, 8388607));
        add_query(make_query(OP_SEGMENT, 8388607, -8388608, -8388608, 8388607,
                             8388607, 8388607));
        add_query(make_query(OP_LINE, 0, 1, 0, -1, 8388607, 0));
        // Every bit of every coordinate gets both values through the extremes
        // above and the random queries below.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            add_query(random_query());
            if (i == RANDOM_ITEMS / 2)
            begin
                // Let the queue drain toward the stall point before holding off.
                wait (query_queue.size() < RANDOM_ITEMS / 4);
                hold_off_cycles = 200;
            end
        end
        stimulus_done = 1'b1;
    end

    // Driver: presents one query at a time with a random gap before each,
    // changing inputs only on the falling edge.
    int       send_gap;
    bit       sending;
    initial
    begin
        in_valid  = 1'b0;
        in_item   = '0;
        out_ready = 1'b0;
        send_gap  = 0;
        sending   = 1'b0;
        rst_n     = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // At the rising edge the driver notes whether the current transfer went
    // through; the falling edge then decides what to present next.
    bit in_taken;
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            distance_queue.insert(distance_queue.size(), predict_distance(in_item));
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                sending  = 1'b0;
                send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
                // Runs of back-to-back transfers.
                if ($urandom_range(0, 3) == 0)
                    send_gap = 0;
            end
            if (!sending)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (query_queue.size() > 0)
                begin
                    in_item  <= query_queue.pop_front();
                    in_valid <= 1'b1;
                    sending  = 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: lowers ready for a random number of cycles after each
    // transfer, plus the one long hold-off requested by the stimulus.
    int  recv_gap;
    int  long_stall;
    bit  out_taken;
    initial
    begin
        recv_gap   = 0;
        long_stall = 0;
    end

    always @(posedge clk)
        out_taken <= rst_n && out_valid && out_ready;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off_cycles > 0)
            begin
                long_stall      = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (out_taken)
                recv_gap = $urandom_range(0, 15);
            if (long_stall > 0)
            begin
                long_stall--;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: each transfer on the output is compared with the oldest
    // prediction, field by field.
    always @(posedge clk)
    begin
        psd_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (distance_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: distance=%0d used=%0b degen=%0b",
                             out_item.distance, out_item.used_endpoint,
                             out_item.degenerate);
            end
            else
            begin
                want = distance_queue.pop_front();
                if (out_item.distance !== want.distance
                    || out_item.used_endpoint !== want.used_endpoint
                    || out_item.degenerate !== want.degenerate)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: distance %0d/%0d used %0b/%0b degen %0b/%0b",
                                 want.distance, out_item.distance,
                                 want.used_endpoint, out_item.used_endpoint,
                                 want.degenerate, out_item.degenerate);
                end
            end
        end
    end

    // Cycle counter with a generous upper bound on the whole run.
    initial
    begin
        cycle_count    = 0;
        mismatch_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // End of run: all queries sent, all predictions consumed, then a drain wait.
    initial
    begin
        wait (stimulus_done);
        wait (query_queue.size() == 0 && !in_valid);
        wait (distance_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && distance_queue.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
